// ===== rtl/core/pplrp_pkg.sv =====
// Shared types and constants for the ping-pong log record packer.
package pplrp_pkg;

	localparam int BUFFER_BYTES_DEF = 512;
	localparam int HEADER_BYTES     = 8;

	// command codes
	localparam logic [1:0] CMD_BEGIN   = 2'd0;
	localparam logic [1:0] CMD_PAYLOAD = 2'd1;
	localparam logic [1:0] CMD_DRAIN   = 2'd2;

	// status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NO_BUF  = 2'd1;
	localparam logic [1:0] ST_IGNORED = 2'd2;

	typedef struct packed {
		logic [1:0]  command;
		logic [31:0] timestamp;
		logic [15:0] entry_type;
		logic [15:0] payload_length;
		logic [7:0]  data_byte;
	} cmd_t;

	typedef struct packed {
		logic [1:0] status;
		logic       out_valid;
		logic [7:0] out_byte;
		logic       out_buffer;
		logic       out_last;
	} rsp_t;

	// result of one item before the drained byte is back from memory
	typedef struct packed {
		logic [1:0] status;
		logic       out_valid;
		logic       out_buffer;
		logic       out_last;
	} tag_t;

endpackage

// ===== rtl/core/pingpong_log_record_packer_unit.sv =====
// Top level of the ping-pong log record packer.
//
//  channel | direction | handshake            | item
//  --------+-----------+----------------------+-----------------
//  cmd     | in        | cmd_valid, cmd_stall | pplrp_pkg::cmd_t
//  rsp     | out       | rsp_valid, rsp_stall | pplrp_pkg::rsp_t
//
// Payload, drain and unused commands do not block the input themselves; a begin that finds room
// blocks it while the rest of its header goes through the single byte write port.
// Each item gives one result through the tag stage and then the output register.
// Reset clears counts and flags at once; the byte store is not cleared.
// A stalled result holds the output register; one more item can sit behind it.
module pingpong_log_record_packer_unit #(
	parameter int BUFFER_BYTES = pplrp_pkg::BUFFER_BYTES_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_valid,
	output logic            cmd_stall,
	input  pplrp_pkg::cmd_t cmd_item,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output pplrp_pkg::rsp_t rsp_item
);
	import pplrp_pkg::*;

	localparam int AW = $clog2(2 * BUFFER_BYTES);

	logic          in_room;
	logic          push;
	tag_t          tag;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [7:0]    wr_data;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic [7:0]    rd_data;

	pplrp_ctrl #(
		.BUFFER_BYTES(BUFFER_BYTES)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd_item (cmd_item),
		.in_room  (in_room),
		.push     (push),
		.tag      (tag),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr)
	);

	pplrp_byte_store #(
		.BUFFER_BYTES(BUFFER_BYTES)
	) u_store (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	pplrp_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.tag      (tag),
		.rd_data  (rd_data),
		.in_room  (in_room),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp_item (rsp_item)
	);

`ifndef ASSERT_OFF
	// the store is never asked to read and write in one cycle
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr_en && rd_en))
		else $error("byte store read and write in the same cycle");

	// a read is only issued for a drain item being taken
	a_read_is_drain: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> (push && cmd_item.command == CMD_DRAIN))
		else $error("byte store read outside a drain");

	// a stored header blocks the input while its remaining bytes go in
	a_hdr_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(push && cmd_item.command == CMD_BEGIN && tag.status == ST_OK) |=> cmd_stall)
		else $error("item taken during header write");

	// last byte flag only on a drained byte with ok status
	a_last_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_item.out_last) |-> (rsp_item.out_valid && rsp_item.status == ST_OK))
		else $error("last flag without a drained byte");
`endif

endmodule

// ===== rtl/core/pplrp_byte_store.sv =====
// Byte-wide store for both buffers: one write port, one registered read port.
module pplrp_byte_store #(
	parameter int BUFFER_BYTES = pplrp_pkg::BUFFER_BYTES_DEF
) (
	input  logic                                clk,
	input  logic                                wr_en,
	input  logic [$clog2(2*BUFFER_BYTES)-1:0]   wr_addr,
	input  logic [7:0]                          wr_data,
	input  logic                                rd_en,
	input  logic [$clog2(2*BUFFER_BYTES)-1:0]   rd_addr,
	output logic [7:0]                          rd_data
);
	import pplrp_pkg::*;

	localparam int DEPTH = 2 * BUFFER_BYTES;

	logic [7:0] mem [DEPTH];
	logic [7:0] rd_data_q;

	// read data only moves on a drain, so it holds while the result waits
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== rtl/core/pplrp_ctrl.sv =====
// Buffer bookkeeping, command decode, header write sequencer and memory requests.
module pplrp_ctrl #(
	parameter int BUFFER_BYTES = pplrp_pkg::BUFFER_BYTES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cmd_valid,
	output logic                                cmd_stall,
	input  pplrp_pkg::cmd_t                     cmd_item,
	input  logic                                in_room,
	output logic                                push,
	output pplrp_pkg::tag_t                     tag,
	output logic                                wr_en,
	output logic [$clog2(2*BUFFER_BYTES)-1:0]   wr_addr,
	output logic [7:0]                          wr_data,
	output logic                                rd_en,
	output logic [$clog2(2*BUFFER_BYTES)-1:0]   rd_addr
);
	import pplrp_pkg::*;

	localparam int CW = $clog2(BUFFER_BYTES + 1);
	localparam int AW = $clog2(2 * BUFFER_BYTES);
	localparam int RW = (CW > 17) ? CW : 17;
	localparam logic [CW-1:0] BUF_MAX = CW'(BUFFER_BYTES);
	localparam logic [AW-1:0] BUF_OFS = AW'(BUFFER_BYTES);

	logic [CW-1:0] fill_q [2];
	logic [CW-1:0] fill_d [2];
	logic [1:0]    full_q, full_d;
	logic          active_q, active_d;
	logic [15:0]   left_q, left_d;
	logic [CW-1:0] ptr_q, ptr_d;
	logic          pl_ok_q, pl_ok_d;
	logic [CW-1:0] dpos_q, dpos_d;
	logic          dbuf_q, dbuf_d;

	logic [2:0]    hdr_left_q;
	logic [55:0]   hdr_data_q;
	logic [AW-1:0] hdr_addr_q;
	logic          hdr_busy;
	logic          hdr_go;

	logic [RW-1:0] room [2];
	logic [RW-1:0] need;
	logic          b_sel;
	logic          ok;
	logic          pick;
	logic          found;
	logic          stop;

	function automatic logic [AW-1:0] buf_addr(input logic b, input logic [CW-1:0] p);
		return b ? (BUF_OFS + AW'(p)) : AW'(p);
	endfunction

	assign hdr_busy  = (hdr_left_q != 3'd0);
	assign cmd_stall = hdr_busy || !in_room;
	assign push      = cmd_valid && !cmd_stall;

	assign room[0] = RW'(BUF_MAX) - RW'(fill_q[0]);
	assign room[1] = RW'(BUF_MAX) - RW'(fill_q[1]);
	assign need    = RW'(cmd_item.payload_length) + RW'(HEADER_BYTES);

	always_comb begin
		fill_d[0] = fill_q[0];
		fill_d[1] = fill_q[1];
		full_d    = full_q;
		active_d  = active_q;
		left_d    = left_q;
		ptr_d     = ptr_q;
		pl_ok_d   = pl_ok_q;
		dpos_d    = dpos_q;
		dbuf_d    = dbuf_q;
		hdr_go    = 1'b0;
		wr_en     = hdr_busy;
		wr_addr   = hdr_addr_q;
		wr_data   = hdr_data_q[7:0];
		rd_en     = 1'b0;
		rd_addr   = '0;
		tag       = '{status: ST_IGNORED, out_valid: 1'b0, out_buffer: 1'b0, out_last: 1'b0};
		b_sel     = active_q;
		ok        = 1'b0;
		pick      = 1'b0;
		found     = 1'b0;
		stop      = 1'b0;
		if (push) begin
			case (cmd_item.command)
				CMD_BEGIN: begin
					left_d  = cmd_item.payload_length;
					pl_ok_d = 1'b0;
					ok      = 1'b1;
					// try the active buffer, then the other one; a failed try marks it full
					if (full_q[b_sel] || room[b_sel] < need) begin
						full_d[b_sel] = 1'b1;
						b_sel         = ~b_sel;
						if (full_q[b_sel] || room[b_sel] < need) begin
							full_d[b_sel] = 1'b1;
							ok            = 1'b0;
						end
					end
					active_d = b_sel;
					if (ok) begin
						fill_d[b_sel] = fill_q[b_sel] + CW'(HEADER_BYTES);
						ptr_d         = fill_q[b_sel] + CW'(HEADER_BYTES);
						pl_ok_d       = 1'b1;
						wr_en         = 1'b1;
						wr_addr       = buf_addr(b_sel, fill_q[b_sel]);
						wr_data       = cmd_item.timestamp[7:0];
						hdr_go        = 1'b1;
						tag.status    = ST_OK;
					end else begin
						tag.status    = ST_NO_BUF;
					end
				end
				CMD_PAYLOAD: begin
					if (left_q != 16'd0) begin
						left_d = left_q - 16'd1;
						if (pl_ok_q && ptr_q < BUF_MAX) begin
							wr_en            = 1'b1;
							wr_addr          = buf_addr(active_q, ptr_q);
							wr_data          = cmd_item.data_byte;
							ptr_d            = ptr_q + CW'(1);
							fill_d[active_q] = ptr_q + CW'(1);
							tag.status       = ST_OK;
						end
					end
				end
				CMD_DRAIN: begin
					// an empty full buffer is cleared and the search moves on
					for (int t = 0; t < 3; t++) begin
						if (!found && !stop) begin
							if (dpos_d != '0 && full_d[dbuf_d]) begin
								pick = dbuf_d;
							end else if (full_d[0]) begin
								pick = 1'b0;
							end else if (full_d[1]) begin
								pick = 1'b1;
							end else begin
								stop = 1'b1;
							end
							if (!stop) begin
								if (pick != dbuf_d) begin
									dpos_d = '0;
								end
								dbuf_d = pick;
								if (dpos_d >= fill_d[pick]) begin
									fill_d[pick] = '0;
									full_d[pick] = 1'b0;
									dpos_d       = '0;
								end else begin
									found          = 1'b1;
									rd_en          = 1'b1;
									rd_addr        = buf_addr(pick, dpos_d);
									tag.status     = ST_OK;
									tag.out_valid  = 1'b1;
									tag.out_buffer = pick;
									dpos_d         = dpos_d + CW'(1);
									if (dpos_d >= fill_d[pick]) begin
										tag.out_last = 1'b1;
										fill_d[pick] = '0;
										full_d[pick] = 1'b0;
										dpos_d       = '0;
									end
								end
							end
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q[0]  <= '0;
			fill_q[1]  <= '0;
			full_q     <= '0;
			active_q   <= 1'b0;
			left_q     <= '0;
			ptr_q      <= '0;
			pl_ok_q    <= 1'b0;
			dpos_q     <= '0;
			dbuf_q     <= 1'b0;
			hdr_left_q <= '0;
		end else begin
			fill_q[0] <= fill_d[0];
			fill_q[1] <= fill_d[1];
			full_q    <= full_d;
			active_q  <= active_d;
			left_q    <= left_d;
			ptr_q     <= ptr_d;
			pl_ok_q   <= pl_ok_d;
			dpos_q    <= dpos_d;
			dbuf_q    <= dbuf_d;
			if (hdr_go) begin
				hdr_left_q <= 3'(HEADER_BYTES - 1);
			end else if (hdr_busy) begin
				hdr_left_q <= hdr_left_q - 3'd1;
			end
		end
	end

	// header bytes 1..7, little endian, one per cycle after the accept
	always_ff @(posedge clk) begin
		if (hdr_go) begin
			hdr_data_q <= {cmd_item.payload_length, cmd_item.entry_type,
				cmd_item.timestamp[31:8]};
			hdr_addr_q <= wr_addr + AW'(1);
		end else if (hdr_busy) begin
			hdr_data_q <= {8'd0, hdr_data_q[55:8]};
			hdr_addr_q <= hdr_addr_q + AW'(1);
		end
	end

endmodule

// ===== rtl/core/pplrp_out_stage.sv =====
// Result path: tag stage waiting on the memory read, then the output register.
module pplrp_out_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  pplrp_pkg::tag_t   tag,
	input  logic [7:0]        rd_data,
	output logic              in_room,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output pplrp_pkg::rsp_t   rsp_item
);
	import pplrp_pkg::*;

	logic  s1_valid_q;
	tag_t  tag_s1;
	logic  s2_valid_q;
	rsp_t  rsp_s2;
	logic  s2_free;
	logic  s1_move;

	assign s2_free = !s2_valid_q || !rsp_stall;
	assign s1_move = s1_valid_q && s2_free;
	assign in_room = !s1_valid_q || s2_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			s2_valid_q <= 1'b0;
		end else begin
			if (push) begin
				s1_valid_q <= 1'b1;
			end else if (s1_move) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_move) begin
				s2_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				s2_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			tag_s1 <= tag;
		end
		if (s1_move) begin
			rsp_s2.status     <= tag_s1.status;
			rsp_s2.out_valid  <= tag_s1.out_valid;
			rsp_s2.out_byte   <= tag_s1.out_valid ? rd_data : 8'd0;
			rsp_s2.out_buffer <= tag_s1.out_buffer;
			rsp_s2.out_last   <= tag_s1.out_last;
		end
	end

	assign rsp_valid = s2_valid_q;
	assign rsp_item  = rsp_s2;

endmodule

// ===== tb/sv/tb_pingpong_log_record_packer_unit.sv =====
// Self-checking testbench for the ping-pong log record packer: directed cases, then random traffic.
module tb_pingpong_log_record_packer_unit;
	import pplrp_pkg::*;

	localparam int BUF = BUFFER_BYTES_DEF;
	localparam int CW = $clog2(BUF) + 1;
	localparam int TOTAL_ITEMS = 1050;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_stall;
	cmd_t cmd_item = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp_item;

	pingpong_log_record_packer_unit #(.BUFFER_BYTES(BUF)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd_item(cmd_item),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp_item(rsp_item)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// predicted state of the two buffers
	logic [7:0]    image_mem [0:2*BUF-1];
	logic [CW-1:0] fill_cnt [2] = '{default: '0};
	logic          full_flg [2] = '{default: 1'b0};
	logic          act_buf = 1'b0;
	logic [15:0]   pay_left = '0;
	logic [CW-1:0] pay_ptr = '0;
	logic          pay_taken = 1'b0;
	logic [CW-1:0] drain_pos = '0;
	logic          drain_buf = 1'b0;

	rsp_t awaited_responses [$];
	int   items_sent = 0;
	int   results_seen = 0;
	int   bytes_drained = 0;
	int   rejected_records = 0;
	int   quiet_pauses = 0;
	int   mismatch_count = 0;
	bit   steady_run = 1'b0;

	function automatic bit no_room(logic b, int need);
		return full_flg[b] || (BUF - int'(fill_cnt[b])) < need;
	endfunction

	function automatic rsp_t predict_packer_result(cmd_t c);
		rsp_t        r;
		int          need;
		int          p;
		logic        b;
		logic [63:0] hdr;
		r = '0;
		r.status = ST_IGNORED;
		case (c.command)
			CMD_BEGIN: begin
				need = HEADER_BYTES + int'(c.payload_length);
				pay_left = c.payload_length;
				pay_taken = 1'b0;
				r.status = ST_OK;
				if (no_room(act_buf, need)) begin
					full_flg[act_buf] = 1'b1;
					act_buf = ~act_buf;
					// second buffer is marked full even when it is empty
					if (no_room(act_buf, need)) begin
						full_flg[act_buf] = 1'b1;
						r.status = ST_NO_BUF;
						rejected_records++;
					end
				end
				if (r.status == ST_OK) begin
					p = int'(act_buf) * BUF + int'(fill_cnt[act_buf]);
					hdr = {c.payload_length, c.entry_type, c.timestamp};
					for (int i = 0; i < HEADER_BYTES; i++)
						image_mem[p + i] = hdr[8*i +: 8];
					fill_cnt[act_buf] = fill_cnt[act_buf] + CW'(HEADER_BYTES);
					pay_ptr = fill_cnt[act_buf];
					pay_taken = 1'b1;
				end
			end
			CMD_PAYLOAD: begin
				if (pay_left != 0) begin
					pay_left--;
					if (pay_taken && pay_ptr < BUF) begin
						image_mem[int'(act_buf) * BUF + int'(pay_ptr)] = c.data_byte;
						pay_ptr++;
						fill_cnt[act_buf] = pay_ptr;
						r.status = ST_OK;
					end
				end
			end
			CMD_DRAIN: begin
				for (int tries = 0; tries < 3 && !r.out_valid; tries++) begin
					if (drain_pos != 0 && full_flg[drain_buf]) b = drain_buf;
					else if (full_flg[0]) b = 1'b0;
					else if (full_flg[1]) b = 1'b1;
					else break;
					if (b != drain_buf || !full_flg[b]) drain_pos = '0;
					drain_buf = b;
					// a full buffer with nothing in it is just cleared
					if (drain_pos >= fill_cnt[b]) begin
						fill_cnt[b] = '0;
						full_flg[b] = 1'b0;
						drain_pos = '0;
						continue;
					end
					r.out_byte = image_mem[int'(b) * BUF + int'(drain_pos)];
					r.out_valid = 1'b1;
					r.out_buffer = b;
					r.status = ST_OK;
					drain_pos++;
					if (drain_pos >= fill_cnt[b]) begin
						r.out_last = 1'b1;
						fill_cnt[b] = '0;
						full_flg[b] = 1'b0;
						drain_pos = '0;
					end
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic cmd_t rand_item(logic [1:0] code);
		cmd_t c;
		c.command = code;
		c.timestamp = $urandom;
		c.entry_type = 16'($urandom_range(16'hFFFF));
		c.payload_length = 16'($urandom_range(16'hFFFF));
		c.data_byte = 8'($urandom_range(255));
		return c;
	endfunction

	task automatic send_item(input cmd_t c);
		while (!steady_run && $urandom_range(99) < 20) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd_item <= c;
		@(posedge clk);
		while (cmd_stall) @(posedge clk);
		awaited_responses.push_back(predict_packer_result(c));
		items_sent++;
	endtask

	task automatic wait_for_all_results();
		cmd_valid <= 1'b0;
		while (awaited_responses.size() != 0) @(posedge clk);
	endtask

	always @(posedge clk)
		rsp_stall <= !steady_run && ($urandom_range(99) < 20);

	function automatic void check_field(string name, int want_v, int got_v);
		if (want_v != got_v) begin
			$error("%s: expected %0d, got %0d", name, want_v, got_v);
			mismatch_count++;
		end
	endfunction

	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			results_seen++;
			if (awaited_responses.size() == 0) begin
				$error("result %h arrived with nothing awaited", rsp_item);
				mismatch_count++;
			end else begin
				want = awaited_responses.pop_front();
				check_field("status", want.status, rsp_item.status);
				check_field("out_valid", want.out_valid, rsp_item.out_valid);
				check_field("out_byte", want.out_byte, rsp_item.out_byte);
				check_field("out_buffer", want.out_buffer, rsp_item.out_buffer);
				check_field("out_last", want.out_last, rsp_item.out_last);
				if (want.out_valid) bytes_drained++;
			end
		end
	end

	task automatic test_idle_commands();
		send_item(rand_item(CMD_DRAIN));
		send_item(rand_item(CMD_PAYLOAD));
		send_item(rand_item(CMD_UNUSED));
	endtask

	task automatic test_record_and_rejection();
		cmd_t c;
		c = rand_item(CMD_BEGIN);
		c.timestamp = '1;
		c.entry_type = '1;
		c.payload_length = 16'd2;
		send_item(c);
		c = rand_item(CMD_PAYLOAD);
		c.data_byte = 8'h00;
		send_item(c);
		c.data_byte = 8'hFF;
		send_item(c);
		send_item(rand_item(CMD_PAYLOAD));
		// longest record fits nowhere: both buffers end up full, one of them empty
		c = rand_item(CMD_BEGIN);
		c.payload_length = '1;
		send_item(c);
		send_item(rand_item(CMD_PAYLOAD));
		c = rand_item(CMD_BEGIN);
		c.payload_length = '0;
		send_item(c);
	endtask

	task automatic test_drain_order();
		// ten bytes from buffer 0, then the empty full buffer 1 is cleared silently
		repeat (11) send_item(rand_item(CMD_DRAIN));
	endtask

	task automatic test_abandoned_payload();
		cmd_t c;
		c = rand_item(CMD_BEGIN);
		c.timestamp = '0;
		c.entry_type = '0;
		c.payload_length = 16'd4;
		send_item(c);
		send_item(rand_item(CMD_PAYLOAD));
		c = rand_item(CMD_BEGIN);
		c.payload_length = '0;
		send_item(c);
	endtask

	task automatic test_random_traffic();
		cmd_t c;
		int   len;
		int   room;
		int   n_pay;
		int   pick;
		int   next_pause;
		next_pause = 300;
		while (items_sent < TOTAL_ITEMS) begin
			steady_run = (items_sent >= 400 && items_sent < 560);
			if (items_sent >= next_pause) begin
				wait_for_all_results();
				quiet_pauses++;
				next_pause += 300;
			end
			pick = $urandom_range(99);
			if (pick < 8) begin
				send_item(rand_item(2'($urandom_range(3))));
			end else if (pick < 38) begin
				if ($urandom_range(9) == 0) begin
					while ((full_flg[0] || full_flg[1]) && items_sent < TOTAL_ITEMS)
						send_item(rand_item(CMD_DRAIN));
				end else begin
					repeat ($urandom_range(1, 24)) send_item(rand_item(CMD_DRAIN));
				end
			end else begin
				room = BUF - int'(fill_cnt[act_buf]) - HEADER_BYTES;
				pick = $urandom_range(99);
				if (pick < 55) len = $urandom_range(6);
				else if (pick < 70) len = $urandom_range(7, 30);
				else if (pick < 80 && room >= 0) len = room;
				else if (pick < 85 && room >= 0) len = room + 1;
				else len = $urandom_range(16'hFFFF);
				c = rand_item(CMD_BEGIN);
				c.payload_length = 16'(len);
				send_item(c);
				pick = $urandom_range(99);
				if (pick < 70) n_pay = len;
				else if (pick < 85) n_pay = $urandom_range(len);
				else n_pay = len + $urandom_range(1, 3);
				if (n_pay > 48) n_pay = 48;
				repeat (n_pay) send_item(rand_item(CMD_PAYLOAD));
			end
		end
		steady_run = 1'b0;
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_idle_commands();
		test_record_and_rejection();
		test_drain_order();
		test_abandoned_payload();
		test_random_traffic();
		wait_for_all_results();
		repeat (16) @(posedge clk);
		$display("Sent %0d items, checked %0d results, %0d of them drained bytes.",
			items_sent, results_seen, bytes_drained);
		$display("Records refused for lack of room: %0d; full quiet pauses: %0d.",
			rejected_records, quiet_pauses);
		if (mismatch_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#2000000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
